### hdl/dcmwa_pkg.sv
`default_nettype none

package dcmwa_pkg;

	// window and sample geometry
	localparam int WINDOW      = 32;
	localparam int SAMPLE_BITS = 12;
	localparam int CNT_W       = $clog2(WINDOW);
	localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);
	localparam int LOG_W       = $clog2(WINDOW + 1) - 1;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	// fixed point gains, unsigned Q0.20
	localparam int GAIN_W    = 16;
	localparam int FRAC_BITS = 20;
	localparam int MUL_A_W   = FRAC_BITS;
	localparam int PROD_W    = MUL_A_W + GAIN_W;
	localparam int WHOLE_W   = SAMPLE_BITS + GAIN_W - FRAC_BITS;

	// result field widths
	localparam int OFFSET_W = 12;
	localparam int WHOLE_OUT_W = 6;
	localparam int HUND_W   = 7;
	localparam int RIP_W    = 4;

	// decimal scaling and saturation limits
	localparam int HUND_SCALE  = 100;
	localparam int TENTH_SCALE = 10;
	localparam int WHOLE_MAX   = 63;
	localparam int HUND_MAX    = 99;
	localparam int RIPPLE_MAX  = 9;

	// reset gains
	localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST = 16'd10800;
	localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = 16'd7749;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 1'b1;

	// result kinds
	localparam logic KIND_CALIBRATION = 1'b0;
	localparam logic KIND_MEASUREMENT = 1'b1;

	// window mean, saturated at the sample maximum
	function automatic logic [SAMPLE_BITS-1:0] mean_of(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] m;
		m = sum >> LOG_W;
		if (m > SUM_W'(SAMPLE_MAX)) begin
			mean_of = SAMPLE_MAX;
		end else begin
			mean_of = m[SAMPLE_BITS-1:0];
		end
	endfunction

endpackage

`default_nettype wire

### hdl/dc_meter_window_averager.sv
`default_nettype none

// channel   handshake                  payload
// sample    sample_valid/sample_stall  voltage_sample, current_sample
// result    result_valid/result_stall  result_kind, zero_offset, volts_*, amps_*, ripple_*
// config    cfg_valid/cfg_ready        cfg_index, cfg_data
//
// a sample that does not close a window is taken without holding the sample channel
// a window-closing sample holds the sample channel through ST_START (calibration)
// or through ST_START to ST_DONE (measurement): six products through one shared 20x16 multiplier
// the sequencer also waits while an earlier result is still held on the result channel
// arst_n clears the gains to their defaults, the window and the calibration; no clearing pass
// cfg_ready is always high; samples keep being taken while a result waits

module dc_meter_window_averager (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                sample_valid,
	output logic                               sample_stall,
	input  wire  [dcmwa_pkg::SAMPLE_BITS-1:0]  voltage_sample,
	input  wire  [dcmwa_pkg::SAMPLE_BITS-1:0]  current_sample,
	output logic                               result_valid,
	input  wire                                result_stall,
	output logic                               result_kind,
	output logic [dcmwa_pkg::OFFSET_W-1:0]     zero_offset,
	output logic [dcmwa_pkg::WHOLE_OUT_W-1:0]  volts_whole,
	output logic [dcmwa_pkg::HUND_W-1:0]       volts_hundredths,
	output logic [dcmwa_pkg::WHOLE_OUT_W-1:0]  amps_whole,
	output logic [dcmwa_pkg::HUND_W-1:0]       amps_hundredths,
	output logic [dcmwa_pkg::RIP_W-1:0]        ripple_whole,
	output logic [dcmwa_pkg::RIP_W-1:0]        ripple_tenths,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [dcmwa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [dcmwa_pkg::GAIN_W-1:0]       cfg_data
);
	import dcmwa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_VFRAC,
		ST_AMUL,
		ST_AFRAC,
		ST_RMUL,
		ST_RFRAC,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0]      vgain_q, cgain_q;
	logic                   cal_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       vsum_q, csum_q;
	logic [SAMPLE_BITS-1:0] peak_q, trough_q;
	logic [OFFSET_W-1:0]    offset_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   sat_q;

	logic                   result_valid_q;
	logic                   kind_q;
	logic [WHOLE_OUT_W-1:0] vwhole_q, awhole_q;
	logic [HUND_W-1:0]      vhund_q, ahund_q;
	logic [RIP_W-1:0]       rwhole_q, rtenth_q;

	logic                   accept;
	logic                   win_end;
	logic [SAMPLE_BITS-1:0] vmean, cmean, cur_diff, ripple;
	logic [MUL_A_W-1:0]     op_a;
	logic [GAIN_W-1:0]      op_b;
	logic [WHOLE_W-1:0]     prod_whole;
	logic                   prod_sat;

	assign accept  = sample_valid && !sample_stall;
	assign win_end = (cnt_q == CNT_W'(WINDOW - 1));

	// window means, offset removal and ripple
	always_comb begin
		vmean    = mean_of(vsum_q);
		cmean    = mean_of(csum_q);
		cur_diff = (cmean < SAMPLE_BITS'(offset_q)) ? '0 : cmean - SAMPLE_BITS'(offset_q);
		ripple   = (peak_q >= trough_q) ? peak_q - trough_q : '0;
	end

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_START: begin
				op_a = MUL_A_W'(vmean);
				op_b = vgain_q;
			end
			ST_VFRAC, ST_AFRAC: begin
				op_a = prod_q[FRAC_BITS-1:0];
				op_b = GAIN_W'(HUND_SCALE);
			end
			ST_AMUL: begin
				op_a = MUL_A_W'(cur_diff);
				op_b = cgain_q;
			end
			ST_RMUL: begin
				op_a = MUL_A_W'(ripple);
				op_b = vgain_q;
			end
			ST_RFRAC: begin
				op_a = prod_q[FRAC_BITS-1:0];
				op_b = GAIN_W'(TENTH_SCALE);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// integer part of the previous product
	assign prod_whole = prod_q[FRAC_BITS +: WHOLE_W];
	assign prod_sat   = (prod_whole > WHOLE_W'(WHOLE_MAX));

	// shared multiplier register
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	// sequencer, window state, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vgain_q        <= VOLTAGE_GAIN_RST;
			cgain_q        <= CURRENT_GAIN_RST;
			cal_q          <= 1'b0;
			cnt_q          <= '0;
			vsum_q         <= '0;
			csum_q         <= '0;
			peak_q         <= '0;
			trough_q       <= SAMPLE_MAX;
			offset_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid) begin
				case (cfg_index)
					REG_VOLTAGE_GAIN: vgain_q <= cfg_data;
					REG_CURRENT_GAIN: cgain_q <= cfg_data;
					default: ;
				endcase
			end

			// result transaction taken downstream
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						csum_q <= csum_q + SUM_W'(current_sample);
						if (cal_q) begin
							vsum_q <= vsum_q + SUM_W'(voltage_sample);
							if (voltage_sample > peak_q) begin
								peak_q <= voltage_sample;
							end
							if (voltage_sample < trough_q) begin
								trough_q <= voltage_sample;
							end
						end
						if (win_end) begin
							cnt_q   <= '0;
							state_q <= ST_START;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_START: begin
					// wait until the result register is free
					if (!result_valid_q) begin
						if (!cal_q) begin
							offset_q       <= OFFSET_W'(cmean);
							cal_q          <= 1'b1;
							kind_q         <= KIND_CALIBRATION;
							vwhole_q       <= '0;
							vhund_q        <= '0;
							awhole_q       <= '0;
							ahund_q        <= '0;
							rwhole_q       <= '0;
							rtenth_q       <= '0;
							result_valid_q <= 1'b1;
							vsum_q         <= '0;
							csum_q         <= '0;
							peak_q         <= '0;
							trough_q       <= SAMPLE_MAX;
							state_q        <= ST_IDLE;
						end else begin
							kind_q  <= KIND_MEASUREMENT;
							state_q <= ST_VFRAC;
						end
					end
				end
				ST_VFRAC: begin
					sat_q    <= prod_sat;
					vwhole_q <= prod_sat ? WHOLE_OUT_W'(WHOLE_MAX)
						: prod_q[FRAC_BITS +: WHOLE_OUT_W];
					state_q  <= ST_AMUL;
				end
				ST_AMUL: begin
					vhund_q <= sat_q ? HUND_W'(HUND_MAX) : prod_q[FRAC_BITS +: HUND_W];
					state_q <= ST_AFRAC;
				end
				ST_AFRAC: begin
					sat_q    <= prod_sat;
					awhole_q <= prod_sat ? WHOLE_OUT_W'(WHOLE_MAX)
						: prod_q[FRAC_BITS +: WHOLE_OUT_W];
					state_q  <= ST_RMUL;
				end
				ST_RMUL: begin
					ahund_q <= sat_q ? HUND_W'(HUND_MAX) : prod_q[FRAC_BITS +: HUND_W];
					state_q <= ST_RFRAC;
				end
				ST_RFRAC: begin
					rwhole_q <= (prod_whole > WHOLE_W'(RIPPLE_MAX)) ? RIP_W'(RIPPLE_MAX)
						: prod_q[FRAC_BITS +: RIP_W];
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					rtenth_q       <= prod_q[FRAC_BITS +: RIP_W];
					result_valid_q <= 1'b1;
					vsum_q         <= '0;
					csum_q         <= '0;
					peak_q         <= '0;
					trough_q       <= SAMPLE_MAX;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// port drive
	assign sample_stall     = (state_q != ST_IDLE);
	assign cfg_ready        = 1'b1;
	assign result_valid     = result_valid_q;
	assign result_kind      = kind_q;
	assign zero_offset      = offset_q;
	assign volts_whole      = vwhole_q;
	assign volts_hundredths = vhund_q;
	assign amps_whole       = awhole_q;
	assign amps_hundredths  = ahund_q;
	assign ripple_whole     = rwhole_q;
	assign ripple_tenths    = rtenth_q;

endmodule

`default_nettype wire

### hdl/dcmwa_checker.sv
`default_nettype none

module dcmwa_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                sample_valid,
	input wire                                sample_stall,
	input wire                                result_valid,
	input wire                                result_stall,
	input wire                                result_kind,
	input wire [dcmwa_pkg::OFFSET_W-1:0]      zero_offset,
	input wire [dcmwa_pkg::WHOLE_OUT_W-1:0]   volts_whole,
	input wire [dcmwa_pkg::HUND_W-1:0]        volts_hundredths,
	input wire [dcmwa_pkg::WHOLE_OUT_W-1:0]   amps_whole,
	input wire [dcmwa_pkg::HUND_W-1:0]        amps_hundredths,
	input wire [dcmwa_pkg::RIP_W-1:0]         ripple_whole,
	input wire [dcmwa_pkg::RIP_W-1:0]         ripple_tenths
);
	import dcmwa_pkg::*;

	// a stalled result transaction stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result transaction keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_kind) && $stable(zero_offset)
			&& $stable(volts_whole) && $stable(volts_hundredths) && $stable(amps_whole)
			&& $stable(amps_hundredths) && $stable(ripple_whole) && $stable(ripple_tenths))
		else $error("result payload changed while stalled");

	// calibration results carry no measurement
	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_CALIBRATION |-> volts_whole == '0
			&& volts_hundredths == '0 && amps_whole == '0 && amps_hundredths == '0
			&& ripple_whole == '0 && ripple_tenths == '0)
		else $error("calibration result with measurement fields");

	// decimal digits stay in range
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> volts_hundredths <= HUND_W'(HUND_MAX)
			&& amps_hundredths <= HUND_W'(HUND_MAX)
			&& ripple_whole <= RIP_W'(RIPPLE_MAX) && ripple_tenths <= RIP_W'(RIPPLE_MAX))
		else $error("decimal digit out of range");

	// the sample channel only stalls after a sample transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_stall) |-> $past(sample_valid && !sample_stall))
		else $error("sample stall without a window end");

endmodule

bind dc_meter_window_averager dcmwa_checker u_dcmwa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample_valid),
	.sample_stall     (sample_stall),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.result_kind      (result_kind),
	.zero_offset      (zero_offset),
	.volts_whole      (volts_whole),
	.volts_hundredths (volts_hundredths),
	.amps_whole       (amps_whole),
	.amps_hundredths  (amps_hundredths),
	.ripple_whole     (ripple_whole),
	.ripple_tenths    (ripple_tenths)
);

`default_nettype wire
